/* sv/pcc_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, codes, state and control types of the PID curvature controller.
package pcc_pkg;

    // Field and datapath widths
    localparam int VAL_W      = 32;  // Q16.16 values and gains
    localparam int TIME_W     = 32;  // millisecond timestamps
    localparam int ERR_W      = 33;  // error, exact
    localparam int DIFF_W     = 34;  // error change, exact
    localparam int MAG_W      = 32;  // magnitude of error and of a gain
    localparam int INT_W      = 64;  // error integral
    localparam int OUT_W      = 24;  // drive output
    localparam int FRAC_W     = 16;  // fraction bits of Q16.16
    localparam int TERM_MAG_W = 48;  // weighted term magnitude, up to 2^47
    localparam int TERM_W     = TERM_MAG_W + 1;
    localparam int SUM_W      = 52;
    localparam int CFG_IDX_W  = 2;

    localparam logic [TERM_MAG_W-1:0] TERM_LIMIT = TERM_MAG_W'(1) << (TERM_MAG_W - 1);
    localparam int OUT_LIMIT = 6553600;  // 100.0 in Q16.16

    // Request kinds
    localparam logic REQ_COMPUTE = 1'b0;
    localparam logic REQ_CLEAR   = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P  = 2'd0,
        CFG_GAIN_I  = 2'd1,
        CFG_GAIN_D  = 2'd2,
        CFG_REVERSE = 2'd3
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_LOAD1,
        S_RUN1,
        S_INTEG,
        S_LOAD2,
        S_RUN2,
        S_TERMS,
        S_SUM1,
        S_SUM2,
        S_SUM3,
        S_CLAMP,
        S_OUT
    } t_state;

    // Strobes from the sequencer to the datapath
    typedef struct packed {
        logic in_ready;
        logic diff_en;
        logic start_md;
        logic integ_en;
        logic start_w;
        logic term_en;
        logic sum1_en;
        logic sum2_en;
        logic sum3_en;
        logic clamp_en;
        logic out_load;
    } t_ctl;

endpackage

/* sv/pcc_if.sv */
`timescale 1ns / 1ps
// Request, result and configuration channel interfaces.
interface pcc_req_if import pcc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic signed [VAL_W-1:0] target_curvature;
    logic signed [VAL_W-1:0] measured_curvature;
    logic [TIME_W-1:0]       sample_time;

    modport source (output valid, req_type, target_curvature, measured_curvature,
                    sample_time, input ready);
    modport sink   (input valid, req_type, target_curvature, measured_curvature,
                    sample_time, output ready);
endinterface

interface pcc_rsp_if import pcc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] turn_value;
    logic                    output_clamped;
    logic                    zero_interval;

    modport source (output valid, turn_value, output_clamped, zero_interval, input ready);
    modport sink   (input valid, turn_value, output_clamped, zero_interval, output ready);
endinterface

interface pcc_cfg_if import pcc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [VAL_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/pcc_mul.sv */
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: one bit of operand A per cycle.
module pcc_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_busy,
    output logic [A_W+B_W-1:0] o_product
);

    localparam int CNT_W = $clog2(A_W + 1);

    logic [A_W+B_W-1:0] r_acc, n_acc;
    logic [B_W-1:0]     r_b;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [B_W:0]       w_sum;

    // Add B into the upper half when the low multiplier bit is set, then shift
    always_comb begin
        w_sum = {1'b0, r_acc[A_W+B_W-1:A_W]} + (r_acc[0] ? {1'b0, r_b} : '0);
        n_acc = {w_sum, r_acc[A_W-1:1]};
        n_cnt = r_cnt - CNT_W'(1);
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(A_W);
        end else if (r_cnt != '0) begin
            r_cnt <= n_cnt;
        end
    end

    // Accumulator and shifting multiplier
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= {{B_W{1'b0}}, i_a};
            r_b   <= i_b;
        end else if (r_cnt != '0) begin
            r_acc <= n_acc;
        end
    end

    assign o_busy    = (r_cnt != '0);
    assign o_product = r_acc;

endmodule

/* sv/pcc_div.sv */
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle, unsigned operands.
module pcc_div #(
    parameter int N_W = 34,
    parameter int D_W = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_busy,
    output logic [N_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [D_W-1:0]   r_rem, n_rem;
    logic [N_W-1:0]   r_nq, n_nq;   // dividend bits out at the top, quotient bits in below
    logic [D_W-1:0]   r_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [D_W:0]     w_trial;
    logic [D_W+1:0]   w_diff;
    logic             w_ge;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        w_trial = {r_rem, r_nq[N_W-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, r_den};
        w_ge    = !w_diff[D_W+1];
        n_rem   = w_ge ? w_diff[D_W-1:0] : w_trial[D_W-1:0];
        n_nq    = {r_nq[N_W-2:0], w_ge};
        n_cnt   = r_cnt - CNT_W'(1);
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(N_W);
        end else if (r_cnt != '0) begin
            r_cnt <= n_cnt;
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_nq  <= i_num;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_nq  <= n_nq;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_nq;

endmodule

/* sv/pid_curvature_controller.sv */
`timescale 1ns / 1ps
// PID curvature controller top level: sequencer, state and serial arithmetic units.
// Compute request: error difference, error x time multiply and 34-step divide, integral
// update, P, 64-bit integral and D term multiplies, terms, sums, clamp, then the output register.
// Clear request: goes straight to the output state and returns the held turn value.
// One request in flight; the next is accepted while the result waits in the output register.
// Synchronous active-low reset zeroes gains, direction and controller state; result channel empty.
module pid_curvature_controller import pcc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    pcc_cfg_if.sink    i_cfg,
    pcc_req_if.sink    i_req,
    pcc_rsp_if.source  o_rsp
);

    localparam int P_PROD_W = 2 * MAG_W;
    localparam int I_PROD_W = INT_W + MAG_W;
    localparam int D_PROD_W = DIFF_W + MAG_W;
    localparam int TOP_BIT  = FRAC_W + TERM_MAG_W;
    localparam logic [INT_W-1:0] SIGN_BIT = INT_W'(1) << (INT_W - 1);
    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(OUT_LIMIT);
    localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_W'(OUT_LIMIT);

    // (magnitude product >> 16), saturated to 2^47, with the sign applied
    function automatic logic signed [TERM_W-1:0] f_term(input logic [I_PROD_W-1:0] prod,
                                                       input logic neg);
        logic                  sat;
        logic [TERM_MAG_W-1:0] mag;
        sat = (|prod[I_PROD_W-1:TOP_BIT]) || (prod[TOP_BIT-1] && (|prod[TOP_BIT-2:FRAC_W]));
        mag = sat ? TERM_LIMIT : prod[TOP_BIT-1:FRAC_W];
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    t_state r_state, n_state;
    t_ctl   w_ctl;

    // Configuration
    logic signed [VAL_W-1:0] r_gain_p, r_gain_i, r_gain_d;
    logic                    r_reverse;

    // Controller state
    logic signed [INT_W-1:0] r_integral;
    logic signed [ERR_W-1:0] r_prev_err;
    logic [TIME_W-1:0]       r_last_time;
    logic signed [OUT_W-1:0] r_held;

    // Per-request working registers
    logic signed [ERR_W-1:0]  r_err;
    logic [TIME_W-1:0]        r_time, r_dt;
    logic signed [DIFF_W-1:0] r_diff;
    logic [MAG_W-1:0]         r_err_mag;
    logic                     r_zero_dt;
    logic [DIFF_W-1:0]        r_deriv_mag;
    logic signed [TERM_W-1:0] r_term_p, r_term_i, r_term_d;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [OUT_W-1:0]  r_res_turn;
    logic                     r_res_clamped, r_res_zero;

    // Output register
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_turn;
    logic                    r_out_clamped, r_out_zero;

    // Combinational datapath
    logic                     w_in_acc, w_clear;
    logic signed [ERR_W-1:0]  w_lhs, w_rhs, w_err_new;
    logic signed [ERR_W-1:0]  w_err_abs;
    logic [DIFF_W-1:0]        w_diff_mag;
    logic [INT_W-1:0]         w_int_mag, w_u, w_int_new;
    logic [INT_W:0]           w_add, w_sub;
    logic [MAG_W-1:0]         w_gain_p_mag, w_gain_i_mag, w_gain_d_mag;
    logic [MAG_W-1:0]         w_mul_p_a, w_mul_p_b;
    logic [P_PROD_W-1:0]      w_prod_p;
    logic [I_PROD_W-1:0]      w_prod_i;
    logic [D_PROD_W-1:0]      w_prod_d;
    logic [DIFF_W-1:0]        w_quot;
    logic                     w_busy_p, w_busy_i, w_busy_d, w_busy_div;
    logic signed [OUT_W-1:0]  w_clamped_out;
    logic                     w_clamp_hit;

    assign w_in_acc = i_req.valid && w_ctl.in_ready;
    assign w_clear  = (i_req.req_type == REQ_CLEAR);

    // Error of the incoming sample, direction folded into the operand order
    always_comb begin
        w_lhs     = r_reverse ? ERR_W'(i_req.measured_curvature) : ERR_W'(i_req.target_curvature);
        w_rhs     = r_reverse ? ERR_W'(i_req.target_curvature) : ERR_W'(i_req.measured_curvature);
        w_err_new = w_lhs - w_rhs;
    end

    // Magnitudes for the serial units
    always_comb begin
        w_err_abs    = r_err[ERR_W-1] ? -r_err : r_err;
        w_diff_mag   = r_diff[DIFF_W-1] ? $unsigned(-r_diff) : $unsigned(r_diff);
        w_int_mag    = r_integral[INT_W-1] ? $unsigned(-r_integral) : $unsigned(r_integral);
        w_gain_p_mag = r_gain_p[VAL_W-1] ? $unsigned(-r_gain_p) : $unsigned(r_gain_p);
        w_gain_i_mag = r_gain_i[VAL_W-1] ? $unsigned(-r_gain_i) : $unsigned(r_gain_i);
        w_gain_d_mag = r_gain_d[VAL_W-1] ? $unsigned(-r_gain_d) : $unsigned(r_gain_d);
    end

    // Saturating integral update in offset-binary form
    always_comb begin
        w_u   = $unsigned(r_integral) ^ SIGN_BIT;
        w_add = {1'b0, w_u} + {1'b0, w_prod_p};
        w_sub = {1'b0, w_u} - {1'b0, w_prod_p};
        if (!r_err[ERR_W-1]) begin
            w_int_new = w_add[INT_W] ? '1 : w_add[INT_W-1:0];
        end else begin
            w_int_new = w_sub[INT_W] ? '0 : w_sub[INT_W-1:0];
        end
        w_int_new = w_int_new ^ SIGN_BIT;
    end

    // Output clamp to +/-100.0
    always_comb begin
        w_clamp_hit   = 1'b1;
        w_clamped_out = OUT_W'(r_sum);
        if (r_sum > SUM_HI) begin
            w_clamped_out = OUT_W'(SUM_HI);
        end else if (r_sum < SUM_LO) begin
            w_clamped_out = OUT_W'(SUM_LO);
        end else begin
            w_clamp_hit = 1'b0;
        end
    end

    // Shared unit: error x elapsed time first, then the proportional term
    assign w_mul_p_a = w_ctl.start_md ? r_dt : r_err_mag;
    assign w_mul_p_b = w_ctl.start_md ? r_err_mag : w_gain_p_mag;

    pcc_mul #(.A_W(MAG_W), .B_W(MAG_W)) u_mul_p (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_ctl.start_md || w_ctl.start_w),
        .i_a       (w_mul_p_a),
        .i_b       (w_mul_p_b),
        .o_busy    (w_busy_p),
        .o_product (w_prod_p)
    );

    pcc_mul #(.A_W(INT_W), .B_W(MAG_W)) u_mul_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_ctl.start_w),
        .i_a       (w_int_mag),
        .i_b       (w_gain_i_mag),
        .o_busy    (w_busy_i),
        .o_product (w_prod_i)
    );

    pcc_mul #(.A_W(DIFF_W), .B_W(MAG_W)) u_mul_d (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_ctl.start_w),
        .i_a       (r_deriv_mag),
        .i_b       (w_gain_d_mag),
        .o_busy    (w_busy_d),
        .o_product (w_prod_d)
    );

    pcc_div #(.N_W(DIFF_W), .D_W(TIME_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.start_md && !r_zero_dt),
        .i_num   (w_diff_mag),
        .i_den   (r_dt),
        .o_busy  (w_busy_div),
        .o_quot  (w_quot)
    );

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc) n_state = w_clear ? S_OUT : S_DIFF;
            S_DIFF:  n_state = S_LOAD1;
            S_LOAD1: n_state = S_RUN1;
            S_RUN1:  if (!w_busy_p && !w_busy_div) n_state = S_INTEG;
            S_INTEG: n_state = S_LOAD2;
            S_LOAD2: n_state = S_RUN2;
            S_RUN2:  if (!w_busy_p && !w_busy_i && !w_busy_d) n_state = S_TERMS;
            S_TERMS: n_state = S_SUM1;
            S_SUM1:  n_state = S_SUM2;
            S_SUM2:  n_state = S_SUM3;
            S_SUM3:  n_state = S_CLAMP;
            S_CLAMP: n_state = S_OUT;
            S_OUT:   if (w_ctl.out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer: strobes
    always_comb begin
        w_ctl = '0;
        unique case (r_state)
            S_IDLE:  w_ctl.in_ready = 1'b1;
            S_DIFF:  w_ctl.diff_en  = 1'b1;
            S_LOAD1: w_ctl.start_md = 1'b1;
            S_RUN1:  ;
            S_INTEG: w_ctl.integ_en = 1'b1;
            S_LOAD2: w_ctl.start_w  = 1'b1;
            S_RUN2:  ;
            S_TERMS: w_ctl.term_en  = 1'b1;
            S_SUM1:  w_ctl.sum1_en  = 1'b1;
            S_SUM2:  w_ctl.sum2_en  = 1'b1;
            S_SUM3:  w_ctl.sum3_en  = 1'b1;
            S_CLAMP: w_ctl.clamp_en = 1'b1;
            S_OUT:   w_ctl.out_load = !r_out_valid || o_rsp.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p  <= '0;
            r_gain_i  <= '0;
            r_gain_d  <= '0;
            r_reverse <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_GAIN_P:  r_gain_p  <= $signed(i_cfg.data);
                CFG_GAIN_I:  r_gain_i  <= $signed(i_cfg.data);
                CFG_GAIN_D:  r_gain_d  <= $signed(i_cfg.data);
                CFG_REVERSE: r_reverse <= i_cfg.data[0];
                default:     ;
            endcase
        end
    end

    // Controller state: cleared by reset; a clear request clears all but the held output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral  <= '0;
            r_prev_err  <= '0;
            r_last_time <= '0;
            r_held      <= '0;
        end else if (w_in_acc && w_clear) begin
            r_integral  <= '0;
            r_prev_err  <= '0;
            r_last_time <= '0;
        end else begin
            if (w_ctl.integ_en) begin
                r_integral <= $signed(w_int_new);
            end
            if (w_ctl.clamp_en) begin
                r_held      <= w_clamped_out;
                r_prev_err  <= r_err;
                r_last_time <= r_time;
            end
        end
    end

    // Working registers of the request in progress
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_err         <= w_err_new;
            r_time        <= i_req.sample_time;
            r_dt          <= i_req.sample_time - r_last_time;
            r_res_turn    <= r_held;
            r_res_clamped <= 1'b0;
            r_res_zero    <= 1'b0;
        end
        if (w_ctl.diff_en) begin
            r_diff    <= DIFF_W'(r_err) - DIFF_W'(r_prev_err);
            r_err_mag <= $unsigned(w_err_abs[MAG_W-1:0]);
            r_zero_dt <= (r_dt == '0);
        end
        if (w_ctl.integ_en) begin
            r_deriv_mag <= r_zero_dt ? '0 : w_quot;
        end
        if (w_ctl.term_en) begin
            r_term_p <= f_term(I_PROD_W'(w_prod_p), r_err[ERR_W-1] ^ r_gain_p[VAL_W-1]);
            r_term_i <= f_term(w_prod_i, r_integral[INT_W-1] ^ r_gain_i[VAL_W-1]);
            r_term_d <= f_term(I_PROD_W'(w_prod_d), r_diff[DIFF_W-1] ^ r_gain_d[VAL_W-1]);
        end
        if (w_ctl.sum1_en) begin
            r_sum <= SUM_W'(r_term_p) + SUM_W'(r_term_i);
        end
        if (w_ctl.sum2_en) begin
            r_sum <= r_sum + SUM_W'(r_term_d);
        end
        if (w_ctl.sum3_en) begin
            r_sum <= r_sum + SUM_W'(r_held);
        end
        if (w_ctl.clamp_en) begin
            r_res_turn    <= w_clamped_out;
            r_res_clamped <= w_clamp_hit;
            r_res_zero    <= r_zero_dt;
        end
    end

    // Result register toward the consumer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.out_load) begin
            r_out_turn    <= r_res_turn;
            r_out_clamped <= r_res_clamped;
            r_out_zero    <= r_res_zero;
        end
    end

    assign i_req.ready          = w_ctl.in_ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.turn_value     = r_out_turn;
    assign o_rsp.output_clamped = r_out_clamped;
    assign o_rsp.zero_interval  = r_out_zero;

endmodule

/* sv/pcc_checker.sv */
`timescale 1ns / 1ps
// Port-level checker of the PID curvature controller and its bind.
module pcc_checker import pcc_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [OUT_W-1:0] i_turn_value,
    input logic                    i_output_clamped,
    input logic                    i_zero_interval
);

    localparam logic signed [OUT_W-1:0] LIM_POS = OUT_W'(OUT_LIMIT);
    localparam logic signed [OUT_W-1:0] LIM_NEG = -OUT_W'(OUT_LIMIT);

    // A pending result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    // A stalled result keeps its fields
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_turn_value) && $stable(i_output_clamped)
                                        && $stable(i_zero_interval))
        else $error("stalled result changed");

    // One request in flight
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while one is in progress");

    // Output never leaves +/-100.0
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_turn_value <= LIM_POS) && (i_turn_value >= LIM_NEG))
        else $error("turn value beyond limit");

    // A clamped result sits exactly on a limit
    a_clamp_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_output_clamped |-> (i_turn_value == LIM_POS)
                                            || (i_turn_value == LIM_NEG))
        else $error("clamp flag without limit value");

endmodule

bind pid_curvature_controller pcc_checker u_pcc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_req.valid),
    .i_in_ready       (i_req.ready),
    .i_out_valid      (o_rsp.valid),
    .i_out_ready      (o_rsp.ready),
    .i_turn_value     (o_rsp.turn_value),
    .i_output_clamped (o_rsp.output_clamped),
    .i_zero_interval  (o_rsp.zero_interval)
);

/* test/pid_curvature_controller_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the PID curvature controller.
module pid_curvature_controller_tb import pcc_pkg::*; ();

    localparam int     RESET_CYCLES   = 10;
    localparam int     DRAIN_CYCLES   = 150;   // idle run after the last result, before the report
    localparam int     WATCHDOG_LIMIT = 3000;  // cycles with no handshake on any channel
    localparam int     HOLD_CYCLES    = 400;   // long result stall in the backpressure test
    localparam int     PHASES         = 6;
    localparam int     PHASE_ITEMS    = 188;
    localparam int     REPORT_MAX     = 10;
    localparam longint OUT_MAX        = OUT_LIMIT;
    localparam longint TERM_MAX       = longint'(1) << 47;
    localparam logic [63:0] INT_BIAS  = 64'd1 << 63;

    // Gain ranges used when choosing random settings
    typedef enum int {
        GAIN_TYPICAL,  // up to +/-4.0
        GAIN_FINE,     // up to +/-0.03125
        GAIN_ANY,      // full 32-bit range
        GAIN_EDGE      // extremes, zero and unity
    } t_gain_style;

    typedef struct {
        logic                    req_type;
        logic signed [VAL_W-1:0] target;
        logic signed [VAL_W-1:0] measured;
        logic [TIME_W-1:0]       sample_time;
    } t_request;

    typedef struct {
        logic signed [OUT_W-1:0] turn_value;
        logic                    output_clamped;
        logic                    zero_interval;
    } t_turn_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pcc_cfg_if cfg_if ();
    pcc_req_if req_if ();
    pcc_rsp_if rsp_if ();

    pid_curvature_controller u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    // Controller shadow: registers and state
    logic signed [VAL_W-1:0] kp, ki, kd;
    logic                    reverse_err;
    longint                  integ_acc, prev_err, held_turn;
    logic [TIME_W-1:0]       last_ms;

    t_turn_result turn_queue[$];

    // Flow control and run statistics
    bit                steady_flow = 1'b0;
    int                rsp_hold    = 0;
    int                rsp_stall   = 0;
    int                stuck_cycles = 0;
    logic [TIME_W-1:0] sim_ms      = '0;
    int n_requests = 0, n_clears = 0, n_results = 0, n_clamped = 0, n_zero_dt = 0;
    int n_settings = 0, n_mismatches = 0;

    // (value * gain) >> 16 toward zero, saturated to +/-2^47
    function automatic longint weigh_term(input longint value,
                                          input logic signed [VAL_W-1:0] gain);
        longint      g, r;
        logic [63:0] mv, mg, hi, lo, m;
        g  = gain;
        mv = (value < 0) ? -value : value;
        mg = (g < 0) ? -g : g;
        hi = (mv >> 32) * mg;
        lo = (mv & 64'hFFFF_FFFF) * mg;
        if (hi >= (64'd1 << 31)) begin
            r = TERM_MAX;
        end else begin
            m = (hi << 16) + (lo >> 16);
            r = (m > TERM_MAX) ? TERM_MAX : longint'(m);
        end
        return ((value < 0) != (g < 0)) ? -r : r;
    endfunction

    // One controller update; returns the turn result the request produces
    function automatic t_turn_result advance_controller(input t_request r);
        t_turn_result res;
        longint       err, rate, total;
        logic [31:0]  dt;
        logic [63:0]  err_mag, area, biased;
        res.output_clamped = 1'b0;
        res.zero_interval  = 1'b0;
        if (r.req_type == REQ_CLEAR) begin
            integ_acc = 0;
            prev_err  = 0;
            last_ms   = '0;
        end else begin
            err = longint'(r.target) - longint'(r.measured);
            if (reverse_err) err = -err;
            dt      = r.sample_time - last_ms;  // wraps with the timer
            err_mag = (err < 0) ? -err : err;
            area    = err_mag * {32'd0, dt};
            // saturating integral, kept in offset binary
            biased = integ_acc ^ INT_BIAS;
            if (err >= 0) biased = (area > ~biased) ? '1 : biased + area;
            else          biased = (area > biased) ? '0 : biased - area;
            integ_acc = longint'(biased ^ INT_BIAS);
            if (dt == 0) begin
                res.zero_interval = 1'b1;
                rate = 0;
            end else begin
                rate = (err - prev_err) / longint'({32'd0, dt});
            end
            total = weigh_term(err, kp) + weigh_term(integ_acc, ki)
                  + weigh_term(rate, kd) + held_turn;
            if (total > OUT_MAX) begin
                total = OUT_MAX;
                res.output_clamped = 1'b1;
            end else if (total < -OUT_MAX) begin
                total = -OUT_MAX;
                res.output_clamped = 1'b1;
            end
            prev_err  = err;
            last_ms   = r.sample_time;
            held_turn = total;
        end
        res.turn_value = held_turn[OUT_W-1:0];
        return res;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VAL_W-1:0] pick_gain(input t_gain_style style);
        logic [VAL_W-1:0] g;
        case (style)
            GAIN_TYPICAL: g = $urandom_range(0, 32'h0004_0000);
            GAIN_FINE:    g = $urandom_range(0, 32'h0000_0800);
            GAIN_ANY:     g = $urandom();
            default: begin
                case ($urandom_range(0, 3))
                    0:       g = 32'h7FFF_FFFF;
                    1:       g = 32'h8000_0000;
                    2:       g = '0;
                    default: g = 32'h0001_0000;
                endcase
            end
        endcase
        if ((style == GAIN_TYPICAL || style == GAIN_FINE) && $urandom_range(0, 1)) g = -g;
        return g;
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_around(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_request build_request(input logic kind,
                                               input logic signed [VAL_W-1:0] target,
                                               input logic signed [VAL_W-1:0] measured,
                                               input logic [TIME_W-1:0] ms);
        t_request r;
        r.req_type    = kind;
        r.target      = target;
        r.measured    = measured;
        r.sample_time = ms;
        return r;
    endfunction

    // Tracking samples on an advancing millisecond clock, plus clears and wideband noise
    function automatic t_request random_request();
        t_request r;
        int       p;
        p = $urandom_range(0, 99);
        r = build_request(REQ_COMPUTE, $urandom(), $urandom(), $urandom());
        if (p < 4) begin
            r.req_type = REQ_CLEAR;
            sim_ms     = '0;
        end else if (p < 14) begin
            sim_ms = r.sample_time;
        end else begin
            r.target   = rand_around(32'h0008_0000);
            r.measured = r.target + rand_around(32'h0002_0000);
            if ($urandom_range(0, 9) != 0) sim_ms = sim_ms + $urandom_range(1, 20);
            r.sample_time = sim_ms;
        end
        return r;
    endfunction

    // Issue one request and record its expected result on acceptance
    task automatic send_request(input t_request r);
        int gap;
        gap = steady_flow ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid              <= 1'b1;
        req_if.req_type           <= r.req_type;
        req_if.target_curvature   <= r.target;
        req_if.measured_curvature <= r.measured;
        req_if.sample_time        <= r.sample_time;
        do @(posedge i_clk); while (!req_if.ready);
        turn_queue.push_back(advance_controller(r));
        n_requests++;
        if (r.req_type == REQ_CLEAR) n_clears++;
    endtask

    // Stop offering requests and wait for every outstanding result
    task automatic settle_requests();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (turn_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [VAL_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_GAIN_P:  kp = data;
            CFG_GAIN_I:  ki = data;
            CFG_GAIN_D:  kd = data;
            CFG_REVERSE: reverse_err = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic load_gains(input logic [VAL_W-1:0] p, input logic [VAL_W-1:0] i,
                              input logic [VAL_W-1:0] d, input logic rev);
        settle_requests();
        cfg_write(CFG_GAIN_P, p);
        cfg_write(CFG_GAIN_I, i);
        cfg_write(CFG_GAIN_D, d);
        cfg_write(CFG_REVERSE, {31'd0, rev});
        n_settings++;
    endtask

    // Unity proportional gain: exact limits, one past them, zero interval, clear
    task automatic test_output_limits();
        load_gains(32'h0001_0000, '0, '0, 1'b0);
        send_request(build_request(REQ_COMPUTE, 0, 0, 0));
        send_request(build_request(REQ_COMPUTE, OUT_LIMIT, 0, 10));
        send_request(build_request(REQ_COMPUTE, 1, 0, 20));
        send_request(build_request(REQ_COMPUTE, -2 * OUT_LIMIT, 0, 30));
        send_request(build_request(REQ_COMPUTE, -1, 0, 40));
        send_request(build_request(REQ_CLEAR, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
        send_request(build_request(REQ_COMPUTE, OUT_LIMIT, 0, 0));
        settle_requests();
    endtask

    // Extreme gains and fields, timer wrap, integral saturation both ways, reversed error
    task automatic test_field_extremes();
        load_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_request(build_request(REQ_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
        send_request(build_request(REQ_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0004));
        send_request(build_request(REQ_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0004));
        send_request(build_request(REQ_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0004));
        send_request(build_request(REQ_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0004));
        send_request(build_request(REQ_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0004));
        load_gains(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_request(build_request(REQ_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0005));
        send_request(build_request(REQ_COMPUTE, 0, 0, 32'h8000_0006));
        send_request(build_request(REQ_COMPUTE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0006));
        send_request(build_request(REQ_COMPUTE, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8001_0000));
        send_request(build_request(REQ_CLEAR, 0, 0, 0));
        send_request(build_request(REQ_COMPUTE, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_0001));
        settle_requests();
    endtask

    // Result side stalls for a long stretch while requests keep coming
    task automatic test_backpressure();
        load_gains(pick_gain(GAIN_TYPICAL), pick_gain(GAIN_FINE), pick_gain(GAIN_TYPICAL),
                   1'b0);
        steady_flow = 1'b1;
        rsp_hold    = HOLD_CYCLES;
        repeat (12) send_request(random_request());
        steady_flow = 1'b0;
        settle_requests();
    endtask

    // Random traffic under a series of gain settings
    task automatic test_random_phases();
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: load_gains(pick_gain(GAIN_TYPICAL), pick_gain(GAIN_FINE),
                              pick_gain(GAIN_TYPICAL), 1'b0);
                1: load_gains(pick_gain(GAIN_TYPICAL), pick_gain(GAIN_TYPICAL),
                              pick_gain(GAIN_TYPICAL), 1'b1);
                2: load_gains(pick_gain(GAIN_ANY), pick_gain(GAIN_ANY),
                              pick_gain(GAIN_ANY), 1'($urandom_range(0, 1)));
                3: load_gains(pick_gain(GAIN_EDGE), pick_gain(GAIN_EDGE),
                              pick_gain(GAIN_EDGE), 1'($urandom_range(0, 1)));
                4: load_gains(pick_gain(GAIN_TYPICAL), pick_gain(GAIN_FINE),
                              pick_gain(GAIN_TYPICAL), 1'b1);
                default: load_gains(pick_gain(GAIN_ANY), pick_gain(GAIN_FINE),
                                    pick_gain(GAIN_EDGE), 1'b0);
            endcase
            // one phase runs with no idling on either side
            steady_flow = (p == 4);
            repeat (PHASE_ITEMS) send_request(random_request());
            steady_flow = 1'b0;
        end
        settle_requests();
    endtask

    // Result ready: long hold when requested, otherwise random stalls
    always @(negedge i_clk) begin
        if (rsp_hold > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold--;
        end else if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall--;
        end else begin
            rsp_if.ready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 3) == 0) rsp_stall = pick_gap();
        end
    end

    // Compare each accepted result with the oldest pending one
    always @(posedge i_clk) begin
        t_turn_result want, got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            n_results++;
            got.turn_value     = rsp_if.turn_value;
            got.output_clamped = rsp_if.output_clamped;
            got.zero_interval  = rsp_if.zero_interval;
            if (turn_queue.size() == 0) begin
                n_mismatches++;
                if (n_mismatches <= REPORT_MAX)
                    $display("%0t: unexpected result turn %0d clamp %0b zero_dt %0b",
                             $realtime, got.turn_value, got.output_clamped,
                             got.zero_interval);
            end else begin
                want = turn_queue.pop_front();
                if (want.output_clamped) n_clamped++;
                if (want.zero_interval) n_zero_dt++;
                if (got.turn_value !== want.turn_value
                        || got.output_clamped !== want.output_clamped
                        || got.zero_interval !== want.zero_interval) begin
                    n_mismatches++;
                    if (n_mismatches <= REPORT_MAX)
                        $display({"%0t: mismatch, expected turn %0d clamp %0b zero_dt %0b,",
                                  " got turn %0d clamp %0b zero_dt %0b"},
                                 $realtime, want.turn_value, want.output_clamped,
                                 want.zero_interval, got.turn_value, got.output_clamped,
                                 got.zero_interval);
                end
            end
        end
    end

    // Watchdog: end the run when no channel has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles, %0d results pending",
                         stuck_cycles, turn_queue.size());
                $display("[pid_curvature_controller] ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n                   = 1'b0;
        req_if.valid              = 1'b0;
        req_if.req_type           = REQ_COMPUTE;
        req_if.target_curvature   = '0;
        req_if.measured_curvature = '0;
        req_if.sample_time        = '0;
        cfg_if.valid              = 1'b0;
        cfg_if.index              = CFG_GAIN_P;
        cfg_if.data               = '0;
        rsp_if.ready              = 1'b0;
        kp          = '0;
        ki          = '0;
        kd          = '0;
        reverse_err = 1'b0;
        integ_acc   = 0;
        prev_err    = 0;
        held_turn   = 0;
        last_ms     = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_output_limits();
        test_field_extremes();
        test_backpressure();
        test_random_phases();

        settle_requests();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests (%0d clears) over %0d gain settings, one long stall.",
                 n_requests, n_clears, n_settings);
        $display("Checked %0d results: %0d at the limit, %0d zero interval, %0d mismatches.",
                 n_results, n_clamped, n_zero_dt, n_mismatches);
        if (n_mismatches == 0 && turn_queue.size() == 0) begin
            $display("[pid_curvature_controller] OK");
        end else begin
            if (turn_queue.size() != 0)
                $display("%0d results never arrived", turn_queue.size());
            $display("[pid_curvature_controller] ERROR");
        end
        $finish;
    end

endmodule
